// ===== src/mprp_pkg.sv =====
// Shared types and constants for the publish packet receive parser.
`timescale 1ns / 1ps
`default_nettype none
package mprp_pkg;

  localparam int TOPIC_MAX   = 128;
  localparam int PAYLOAD_MAX = 256;

  localparam int REM_W   = 28;
  localparam int TLEN_W  = 16;
  localparam int PCNT_W  = $clog2(PAYLOAD_MAX + 2);
  localparam int LIDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TOPIC,
    KIND_PAYLOAD,
    KIND_END,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic        truncated;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage
`default_nettype wire

// ===== src/mprp_byte_if.sv =====
// Input channel: one received packet byte per beat.
`timescale 1ns / 1ps
`default_nettype none
interface mprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== src/mprp_result_if.sv =====
// Output channel: one parsed result per beat.
`timescale 1ns / 1ps
`default_nettype none
interface mprp_result_if;
  logic                valid;
  logic                ready;
  mprp_pkg::kind_t     out_kind;
  logic [7:0]          out_byte;
  logic                out_last;
  logic                truncated;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  output truncated, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  input truncated, output ready);
endinterface
`default_nettype wire

// ===== src/mprp_front.sv =====
// Front end: packet phase tracking, length decode and byte classification.
`timescale 1ns / 1ps
`default_nettype none
module mprp_front (
  input  logic              clk,
  input  logic              rst,
  mprp_byte_if.sink         rx,
  input  logic              q_full,
  output mprp_pkg::push_t   push
);
  import mprp_pkg::*;

  phase_t                phase, phase_next;
  logic [REM_W-1:0]      remaining, remaining_next;
  logic [LIDX_W-1:0]     len_idx, len_idx_next;
  logic [TLEN_W-1:0]     topic_length, topic_length_next;
  logic [TLEN_W-1:0]     topic_count, topic_count_next;
  logic [PCNT_W-1:0]     payload_count, payload_count_next;
  logic                  dropped, dropped_next;

  logic                  accept;
  logic [7:0]            b;
  logic [REM_W-1:0]      len_group;
  logic [REM_W-1:0]      rem_len;
  logic [REM_W-1:0]      rem_dec;
  logic                  rem_dec_zero;
  logic [TLEN_W-1:0]     tl_full;
  logic                  tl_over;
  logic [TLEN_W-1:0]     tc_inc;
  logic                  topic_keep;
  logic [PCNT_W-1:0]     pc_inc;
  logic                  payload_keep;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // 7-bit group placed by its position, low group first
  always_comb begin
    case (len_idx)
      2'd0:    len_group = {21'd0, b[6:0]};
      2'd1:    len_group = {14'd0, b[6:0], 7'd0};
      2'd2:    len_group = {7'd0, b[6:0], 14'd0};
      default: len_group = {b[6:0], 21'd0};
    endcase
  end

  assign rem_len      = remaining + len_group;
  assign rem_dec      = remaining - REM_W'(1);
  assign rem_dec_zero = (rem_dec == '0);
  assign tl_full      = {topic_length[15:8], b};
  assign tl_over      = {{(REM_W-TLEN_W){1'b0}}, tl_full} > rem_dec;
  assign tc_inc       = topic_count + TLEN_W'(1);
  assign topic_keep   = tc_inc <= TLEN_W'(TOPIC_MAX);
  assign pc_inc       = (payload_count == PCNT_W'(PAYLOAD_MAX + 1)) ? payload_count
                                                                   : payload_count + PCNT_W'(1);
  assign payload_keep = pc_inc <= PCNT_W'(PAYLOAD_MAX);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HEADER: phase_next = PH_LENGTH;
        PH_LENGTH: begin
          if (b[7]) begin
            if (len_idx == LIDX_W'(3)) phase_next = PH_HEADER;
          end else if (rem_len == '0) begin
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_TLEN_HI;
          end
        end
        PH_TLEN_HI: phase_next = rem_dec_zero ? PH_HEADER : PH_TLEN_LO;
        PH_TLEN_LO: begin
          if (tl_over)           phase_next = rem_dec_zero ? PH_HEADER : PH_SKIP;
          else if (rem_dec_zero) phase_next = PH_HEADER;
          else                   phase_next = (tl_full != '0) ? PH_TOPIC : PH_PAYLOAD;
        end
        PH_TOPIC: begin
          if (tc_inc >= topic_length) phase_next = rem_dec_zero ? PH_HEADER : PH_PAYLOAD;
        end
        PH_PAYLOAD: if (rem_dec_zero) phase_next = PH_HEADER;
        PH_SKIP:    if (rem_dec_zero) phase_next = PH_HEADER;
        default:    phase_next = PH_HEADER;
      endcase
    end
  end

  // counters and the result beat
  always_comb begin
    remaining_next     = remaining;
    len_idx_next       = len_idx;
    topic_length_next  = topic_length;
    topic_count_next   = topic_count;
    payload_count_next = payload_count;
    dropped_next       = dropped;
    push.valid         = 1'b0;
    push.res           = '{kind: KIND_END, data: 8'd0, last: 1'b0, truncated: 1'b0};
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          remaining_next     = '0;
          len_idx_next       = '0;
          topic_length_next  = '0;
          topic_count_next   = '0;
          payload_count_next = '0;
          dropped_next       = 1'b0;
        end
        PH_LENGTH: begin
          remaining_next = rem_len;
          if (b[7]) begin
            if (len_idx == LIDX_W'(3)) begin
              push.valid = 1'b1;
              push.res   = '{kind: KIND_BAD, data: 8'd0, last: 1'b1, truncated: 1'b0};
            end else begin
              len_idx_next = len_idx + LIDX_W'(1);
            end
          end else if (rem_len == '0) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_BAD, data: 8'd0, last: 1'b1, truncated: 1'b0};
          end
        end
        PH_TLEN_HI: begin
          remaining_next    = rem_dec;
          topic_length_next = {b, 8'd0};
          if (rem_dec_zero) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_BAD, data: 8'd0, last: 1'b1, truncated: 1'b0};
          end
        end
        PH_TLEN_LO: begin
          remaining_next    = rem_dec;
          topic_length_next = tl_full;
          if (tl_over) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_BAD, data: 8'd0, last: 1'b1, truncated: 1'b0};
          end else if (rem_dec_zero) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_END, data: 8'd0, last: 1'b1, truncated: dropped};
          end
        end
        PH_TOPIC: begin
          remaining_next   = rem_dec;
          topic_count_next = tc_inc;
          dropped_next     = dropped || !topic_keep;
          if (topic_keep) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_TOPIC, data: b, last: rem_dec_zero,
                           truncated: rem_dec_zero && dropped_next};
          end else if (rem_dec_zero) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_END, data: 8'd0, last: 1'b1, truncated: dropped_next};
          end
        end
        PH_PAYLOAD: begin
          remaining_next     = rem_dec;
          payload_count_next = pc_inc;
          dropped_next       = dropped || !payload_keep;
          if (payload_keep) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_PAYLOAD, data: b, last: rem_dec_zero,
                           truncated: rem_dec_zero && dropped_next};
          end else if (rem_dec_zero) begin
            push.valid = 1'b1;
            push.res   = '{kind: KIND_END, data: 8'd0, last: 1'b1, truncated: dropped_next};
          end
        end
        PH_SKIP: remaining_next = rem_dec;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      remaining     <= '0;
      len_idx       <= '0;
      topic_length  <= '0;
      topic_count   <= '0;
      payload_count <= '0;
      dropped       <= 1'b0;
    end else begin
      phase         <= phase_next;
      remaining     <= remaining_next;
      len_idx       <= len_idx_next;
      topic_length  <= topic_length_next;
      topic_count   <= topic_count_next;
      payload_count <= payload_count_next;
      dropped       <= dropped_next;
    end
  end

  a_header_starts_length: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_HEADER) |=> (phase == PH_LENGTH && remaining == '0 && !dropped))
    else $error("header byte did not restart length decode");

  a_last_closes_packet: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.res.last) |=> (phase == PH_HEADER || phase == PH_SKIP))
    else $error("closing beat left parser mid-packet");

endmodule
`default_nettype wire

// ===== src/mprp_queue.sv =====
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module mprp_queue (
  input  logic              clk,
  input  logic              rst,
  input  mprp_pkg::push_t   push,
  output logic              full,
  output logic              q_valid,
  output mprp_pkg::result_t q_res,
  input  logic              q_pop
);
  import mprp_pkg::*;

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_res   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push.valid && !q_pop)      count_next = count + QCNT_W'(1);
    else if (!push.valid && q_pop) count_next = count - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (q_pop)      rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !q_pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("push lost");

endmodule
`default_nettype wire

// ===== src/mprp_back.sv =====
// Output stage: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module mprp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mprp_pkg::result_t q_res,
  output logic              q_pop,
  mprp_result_if.source     res
);
  import mprp_pkg::*;

  logic    out_valid;
  result_t hold;

  assign q_pop = q_valid && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_res;
  end

  assign res.valid     = out_valid;
  assign res.out_kind  = hold.kind;
  assign res.out_byte  = hold.data;
  assign res.out_last  = hold.last;
  assign res.truncated = hold.truncated;

endmodule
`default_nettype wire

// ===== src/mqtt_publish_receive_parser_unit.sv =====
// Top level of the QoS-0 publish packet receive parser.
`timescale 1ns / 1ps
`default_nettype none
// Feed received packet bytes on rx, one byte per beat, in wire order. The
// first byte of each packet (fixed header) is skipped, then the 1 to 4 byte
// remaining length is decoded, then the 16-bit big-endian topic length.
// Every topic byte and payload byte comes out on res as one beat tagged
// with its kind (topic, payload); the beat for the packet's final byte has
// out_last set, and then truncated tells whether any byte was dropped.
// Topic bytes past TOPIC_MAX and payload bytes past PAYLOAD_MAX (package
// constants) are dropped; if the final byte is dropped an "end" beat
// closes the packet instead. A fourth length byte with bit 7 set, a zero
// or one byte remaining length, or a topic longer than the remaining
// length gives one "malformed" beat with out_last set; the rest of that
// packet, as far as its length is known, is skipped and the parser
// resyncs on the next one. Rate: one byte per clock while the queue has
// room. The front end updates its phase and counters once per byte; a
// 4-beat queue and an output register decouple it from res, so rx stays
// ready while the queue has room. Each result goes into the queue, then
// into the output register, which drives res.valid. Configuration: none.
// Reset: synchronous, active high, clears all but queue and output data.
module mqtt_publish_receive_parser_unit (
  input  logic          clk,
  input  logic          rst,
  mprp_byte_if.sink     rx,
  mprp_result_if.source res
);
  import mprp_pkg::*;

  push_t   push;
  logic    q_full;
  logic    q_valid;
  result_t q_res;
  logic    q_pop;

  // byte classification and packet state
  mprp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .push   (push)
  );

  // decoupling queue
  mprp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_res   (q_res),
    .q_pop   (q_pop)
  );

  // registered output beat
  mprp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_res   (q_res),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
`default_nettype wire
